// ===== sv/lpwan_frame_field_parser_core_macros.svh =====
// Assertion macros shared by the frame field parser modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef LPWAN_FRAME_FIELD_PARSER_CORE_MACROS_SVH
`define LPWAN_FRAME_FIELD_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LFFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LFFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lffp_pkg.sv =====
// Package for the frame field parser: word types, field codes, kind codes.
// Used by lffp_classify and lpwan_frame_field_parser_core; no dependencies.
package lffp_pkg;

    // Largest frame length that is not flagged malformed.
    localparam int unsigned MAX_FRAME_BYTES = 255;

    // Field codes carried in field_id.
    typedef enum logic [4:0] {
        F_MHDR     = 5'd0,
        F_APPEUI   = 5'd1,
        F_DEVEUI   = 5'd2,
        F_DEVNONCE = 5'd3,
        F_APPNONCE = 5'd4,
        F_NETID    = 5'd5,
        F_DEVADDR  = 5'd6,
        F_DLSET    = 5'd7,
        F_RXDELAY  = 5'd8,
        F_CFLIST   = 5'd9,
        F_FCTRL    = 5'd10,
        F_FCNT     = 5'd11,
        F_FOPTS    = 5'd12,
        F_FPORT    = 5'd13,
        F_PAYLOAD  = 5'd14,
        F_MIC      = 5'd15,
        F_UNUSED   = 5'd16
    } field_t;

    // Message kinds from MHDR bits 7..5.
    localparam logic [2:0] KIND_JOIN_REQ    = 3'd0;
    localparam logic [2:0] KIND_JOIN_ACCEPT = 3'd1;
    localparam logic [2:0] KIND_UNCONF_UP   = 3'd2;
    localparam logic [2:0] KIND_UNCONF_DOWN = 3'd3;
    localparam logic [2:0] KIND_CONF_UP     = 3'd4;
    localparam logic [2:0] KIND_CONF_DOWN   = 3'd5;
    localparam logic [2:0] KIND_REJOIN      = 3'd6;
    localparam logic [2:0] KIND_PROPRIETARY = 3'd7;

    // Minimum frame lengths per layout.
    localparam logic [7:0] MIN_LEN_JOIN_REQ    = 8'd23;
    localparam logic [7:0] MIN_LEN_JOIN_ACCEPT = 8'd17;
    localparam logic [7:0] MIN_LEN_DATA_BASE   = 8'd12;
    localparam logic [7:0] MIN_LEN_OTHER       = 8'd5;
    localparam logic [7:0] CFLIST_FRAME_LEN    = 8'd33;

    // Input word: one frame byte with its framing information.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic [7:0] frame_length;
    } in_word_t;

    // Output word: the byte tagged with its field.
    typedef struct packed {
        field_t     field_id;
        logic [7:0] field_byte;
        logic [7:0] field_pos;
        logic       field_last;
        logic [2:0] message_kind;
        logic       downlink;
        logic       malformed;
    } out_word_t;

    // Field tag produced by the classifier.
    typedef struct packed {
        field_t     id;
        logic [7:0] pos;
        logic       last;
    } tag_t;

endpackage

// ===== sv/lffp_classify.sv =====
// Field classifier: maps a byte index within a frame to its field tag.
// Depends on lffp_pkg for the field codes, kind codes and tag_t.
module lffp_classify (
    input  logic [7:0]    idx,
    input  logic [7:0]    frame_len,
    input  logic [2:0]    kind,
    input  logic [3:0]    opt_len,
    output lffp_pkg::tag_t tag
);
    import lffp_pkg::*;

    logic [7:0] mic_first;
    logic [7:0] port_idx;
    logic [7:0] first_idx;
    logic [7:0] last_idx;
    logic       hit;
    field_t     id;

    // MIC starts four bytes before the end; short frames put it right after MHDR.
    assign mic_first = (frame_len > 8'd4) ? (frame_len - 8'd4) : 8'd1;
    assign port_idx  = 8'd8 + {4'd0, opt_len};

    // Pick the field by precedence: beyond length, MHDR, MIC, then the layout.
    always_comb
    begin
        id        = F_UNUSED;
        first_idx = 8'd0;
        last_idx  = 8'd0;
        hit       = 1'b0;
        priority if (idx >= frame_len)
        begin
            hit = 1'b0;
        end
        else if (idx == 8'd0)
        begin
            id  = F_MHDR;
            hit = 1'b1;
        end
        else if (idx >= mic_first)
        begin
            id        = F_MIC;
            first_idx = mic_first;
            last_idx  = frame_len - 8'd1;
            hit       = 1'b1;
        end
        else
        begin
            unique case (kind)
                KIND_JOIN_REQ:
                begin
                    priority if (idx <= 8'd8)
                    begin
                        id = F_APPEUI;   first_idx = 8'd1;  last_idx = 8'd8;  hit = 1'b1;
                    end
                    else if (idx <= 8'd16)
                    begin
                        id = F_DEVEUI;   first_idx = 8'd9;  last_idx = 8'd16; hit = 1'b1;
                    end
                    else if (idx <= 8'd18)
                    begin
                        id = F_DEVNONCE; first_idx = 8'd17; last_idx = 8'd18; hit = 1'b1;
                    end
                    else
                    begin
                        // Bytes between DevNonce and the MIC belong to no field.
                        hit = 1'b0;
                    end
                end
                KIND_JOIN_ACCEPT:
                begin
                    priority if (idx <= 8'd3)
                    begin
                        id = F_APPNONCE; first_idx = 8'd1;  last_idx = 8'd3;  hit = 1'b1;
                    end
                    else if (idx <= 8'd6)
                    begin
                        id = F_NETID;    first_idx = 8'd4;  last_idx = 8'd6;  hit = 1'b1;
                    end
                    else if (idx <= 8'd10)
                    begin
                        id = F_DEVADDR;  first_idx = 8'd7;  last_idx = 8'd10; hit = 1'b1;
                    end
                    else if (idx == 8'd11)
                    begin
                        id = F_DLSET;    first_idx = 8'd11; last_idx = 8'd11; hit = 1'b1;
                    end
                    else if (idx == 8'd12)
                    begin
                        id = F_RXDELAY;  first_idx = 8'd12; last_idx = 8'd12; hit = 1'b1;
                    end
                    else if (frame_len == CFLIST_FRAME_LEN && idx <= 8'd28)
                    begin
                        id = F_CFLIST;   first_idx = 8'd13; last_idx = 8'd28; hit = 1'b1;
                    end
                    else
                    begin
                        // Without a CFList the bytes after RxDelay are unused.
                        hit = 1'b0;
                    end
                end
                KIND_UNCONF_UP, KIND_UNCONF_DOWN, KIND_CONF_UP, KIND_CONF_DOWN:
                begin
                    priority if (idx <= 8'd4)
                    begin
                        id = F_DEVADDR; first_idx = 8'd1; last_idx = 8'd4; hit = 1'b1;
                    end
                    else if (idx == 8'd5)
                    begin
                        id = F_FCTRL;   first_idx = 8'd5; last_idx = 8'd5; hit = 1'b1;
                    end
                    else if (idx <= 8'd7)
                    begin
                        id = F_FCNT;    first_idx = 8'd6; last_idx = 8'd7; hit = 1'b1;
                    end
                    else if (idx < port_idx)
                    begin
                        id = F_FOPTS;   first_idx = 8'd8; last_idx = port_idx - 8'd1;
                        hit = 1'b1;
                    end
                    else if (idx == port_idx)
                    begin
                        id = F_FPORT;   first_idx = port_idx; last_idx = port_idx;
                        hit = 1'b1;
                    end
                    else
                    begin
                        id = F_PAYLOAD; first_idx = port_idx + 8'd1;
                        last_idx = mic_first - 8'd1;
                        hit = 1'b1;
                    end
                end
                default:
                begin
                    // Rejoin and proprietary frames carry only MHDR and MIC.
                    hit = 1'b0;
                end
            endcase
        end
    end

    // Position counts from the field's first byte; untagged bytes report zero.
    always_comb
    begin
        tag.id   = id;
        tag.pos  = hit ? (idx - first_idx) : 8'd0;
        tag.last = hit && (idx == last_idx);
    end

endmodule

// ===== sv/lpwan_frame_field_parser_core.sv =====
// Top level of the frame field parser: handshake, frame state and result register.
// Depends on lffp_pkg, lffp_classify and lpwan_frame_field_parser_core_macros.svh.
//
// The parser takes one frame byte per word and returns one tagged word for each,
// at a sustained rate of one word per cycle while tag_stall is low. A word is
// captured in an input register, classified and checked in the next cycle, and
// lands in the result register; while the output side stalls it waits in the
// input register. The frame state (byte index, kind, FOpts length, length) is
// read by the classifier and updated in the same cycle as the classification,
// and this loop sets the rate. frame_stall follows tag_stall combinationally
// when both registers are full.
`include "lpwan_frame_field_parser_core_macros.svh"

module lpwan_frame_field_parser_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                frame_valid,
    output logic                frame_stall,
    input  lffp_pkg::in_word_t  frame_word,
    output logic                tag_valid,
    input  logic                tag_stall,
    output lffp_pkg::out_word_t tag_word
);
    import lffp_pkg::*;

    in_word_t   s1_reg;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    out_word_t  res_reg;
    out_word_t  res_next;
    logic       res_valid_reg;
    logic       res_valid_next;

    logic [7:0] byte_count_reg;
    logic [7:0] byte_count_next;
    logic [2:0] kind_reg;
    logic [2:0] kind_next;
    logic [3:0] opt_len_reg;
    logic [3:0] opt_len_next;
    logic [7:0] length_reg;
    logic [7:0] length_next;

    logic       accept;
    logic       s1_go;
    logic [7:0] idx;
    logic [3:0] opt_cur;
    logic [7:0] min_len;
    tag_t       tag;

    // Handshake: the input register moves on whenever the result register is free or being read out.
    assign s1_go       = s1_valid_reg && (!res_valid_reg || !tag_stall);
    assign frame_stall = s1_valid_reg && !s1_go;
    assign accept      = frame_valid && !frame_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_go);
    assign res_valid_next = s1_go || (res_valid_reg && tag_stall);

    // Frame context seen by this byte; a start word reloads it, keeping the old kind when the frame length is zero.
    always_comb
    begin
        idx         = byte_count_reg;
        length_next = length_reg;
        kind_next   = kind_reg;
        opt_cur     = opt_len_reg;
        if (s1_reg.frame_start)
        begin
            idx         = 8'd0;
            length_next = s1_reg.frame_length;
            opt_cur     = 4'd0;
            if (s1_reg.frame_length != 8'd0)
            begin
                kind_next = s1_reg.data_byte[7:5];
            end
        end
    end

    lffp_classify u_classify (
        .idx       (idx),
        .frame_len (length_next),
        .kind      (kind_next),
        .opt_len   (opt_cur),
        .tag       (tag)
    );

    // FOpts length is taken from the FCtrl byte; the byte index saturates.
    assign opt_len_next    = (tag.id == F_FCTRL) ? s1_reg.data_byte[3:0] : opt_cur;
    assign byte_count_next = (idx != 8'hff) ? (idx + 8'd1) : 8'hff;

    // Minimum length for the layout, using the FOpts length known so far.
    always_comb
    begin
        unique case (kind_next)
            KIND_JOIN_REQ:    min_len = MIN_LEN_JOIN_REQ;
            KIND_JOIN_ACCEPT: min_len = MIN_LEN_JOIN_ACCEPT;
            KIND_UNCONF_UP, KIND_UNCONF_DOWN, KIND_CONF_UP, KIND_CONF_DOWN:
                min_len = MIN_LEN_DATA_BASE + {4'd0, opt_len_next};
            default:          min_len = MIN_LEN_OTHER;
        endcase
    end

    // Result word.
    always_comb
    begin
        res_next.field_id     = tag.id;
        res_next.field_byte   = s1_reg.data_byte;
        res_next.field_pos    = tag.pos;
        res_next.field_last   = tag.last;
        res_next.message_kind = kind_next;
        res_next.downlink     = (kind_next == KIND_JOIN_ACCEPT)
                             || (kind_next == KIND_UNCONF_DOWN)
                             || (kind_next == KIND_CONF_DOWN);
        res_next.malformed    = (length_next < min_len)
                             || ({1'b0, length_next} > 9'(MAX_FRAME_BYTES));
    end

    // Control and frame state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            byte_count_reg <= 8'd0;
            kind_reg       <= 3'd0;
            opt_len_reg    <= 4'd0;
            length_reg     <= 8'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (s1_go)
            begin
                byte_count_reg <= byte_count_next;
                kind_reg       <= kind_next;
                opt_len_reg    <= opt_len_next;
                length_reg     <= length_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= frame_word;
        end
        if (s1_go)
        begin
            res_reg <= res_next;
        end
    end

    assign tag_valid = res_valid_reg;
    assign tag_word  = res_reg;

    // Checks on the frame state and the tagging.
    `LFFP_ASSERT_NOW(a_stall_needs_word, frame_stall, s1_valid_reg && res_valid_reg,
        "input stalled without a word held in both registers")
    `LFFP_ASSERT_NEXT(a_count_steps,
        s1_go && !s1_reg.frame_start && (byte_count_reg != 8'hff),
        byte_count_reg == ($past(byte_count_reg) + 8'd1),
        "byte index did not advance by one within a frame")
    `LFFP_ASSERT_NOW(a_unused_clean, tag_valid && (tag_word.field_id == F_UNUSED),
        (tag_word.field_pos == 8'd0) && !tag_word.field_last,
        "unused byte carries a position or end mark")
    `LFFP_ASSERT_NOW(a_mhdr_single, tag_valid && (tag_word.field_id == F_MHDR),
        (tag_word.field_pos == 8'd0) && tag_word.field_last,
        "MHDR byte not tagged as a one-byte field")
    `LFFP_ASSERT_NOW(a_downlink_kind, tag_valid && tag_word.downlink,
        (tag_word.message_kind == KIND_JOIN_ACCEPT) ||
        (tag_word.message_kind == KIND_UNCONF_DOWN) ||
        (tag_word.message_kind == KIND_CONF_DOWN),
        "downlink flagged for an uplink or reserved kind")

endmodule
